[sv/btb_history_xor_predictor_defines.svh]
// Assertion macros for the branch target buffer predictor.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef BTB_HISTORY_XOR_PREDICTOR_DEFINES_SVH
`define BTB_HISTORY_XOR_PREDICTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BHXP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BHXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bhxp_pkg.sv]
// Shared types and constants for the branch target buffer predictor.
// No dependencies.
package bhxp_pkg;

    localparam int INDEX_BITS  = 10;
    localparam int TAG_BITS    = 4;
    localparam int PC_W        = 32;
    localparam int TAG_LSB     = INDEX_BITS + 2;
    localparam int ENTRY_W     = TAG_BITS + PC_W;
    localparam int IN_DATA_W   = 3 * PC_W;
    localparam int OUT_USER_W  = 3;

    // Major opcodes, instruction[6:2]
    typedef enum logic [4:0] {
        OPC_BRANCH = 5'd24,
        OPC_JALR   = 5'd25,
        OPC_JAL    = 5'd27
    } t_opcode;

    typedef logic [INDEX_BITS-1:0] t_slot;
    typedef logic [TAG_BITS-1:0]   t_tag;

    // One buffer entry as stored in the RAM
    typedef struct packed {
        t_tag            tag;
        logic [PC_W-1:0] target;
    } t_entry;

    // Lookup info handed from the index unit to the pipeline
    typedef struct packed {
        t_slot slot;
        t_tag  tag;
        logic  ctl;
    } t_lookup;

endpackage

[sv/bhxp_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bhxp_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 36
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/bhxp_index.sv]
// Index unit: global history register, opcode decode, slot and tag.
// Depends on bhxp_pkg.
module bhxp_index
    import bhxp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [PC_W-1:0] i_pc,
    input  logic [4:0]      i_opcode,
    output t_lookup         o_lookup
);

    t_slot r_hist;
    t_slot n_hist;
    logic  ctl;
    logic [1:0] fold;

    // Control transfer decode
    always_comb begin
        unique case (i_opcode) inside
            OPC_BRANCH, OPC_JALR, OPC_JAL: ctl = 1'b1;
            default:                       ctl = 1'b0;
        endcase
    end

    // History shifts two places and folds in pc[3:2]^pc[5:4]
    assign fold   = i_pc[3:2] ^ i_pc[5:4];
    assign n_hist = {r_hist[INDEX_BITS-3:0], 2'b00}
                  ^ {{(INDEX_BITS-2){1'b0}}, fold};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_accept && ctl) begin
            r_hist <= n_hist;
        end
    end

    assign o_lookup.slot = i_pc[INDEX_BITS+1:2] ^ r_hist;
    assign o_lookup.tag  = i_pc[TAG_LSB+TAG_BITS-1:TAG_LSB];
    assign o_lookup.ctl  = ctl;

endmodule

[sv/btb_history_xor_predictor.sv]
// Top level of the gshare-indexed branch target buffer predictor.
// Depends on bhxp_pkg, bhxp_index, bhxp_ram and the assertion macro header.
//
//  channel  dir  width  contents
//  s        in   96     tdata: pc[31:0], instruction[63:32], actual_next_pc[95:64]
//  m        out  32+3   tdata: predicted_next_pc; tuser: hit, ctl, mispredicted
//
//  One beat per cycle sustained while m does not stall; a beat passes through the
//  lookup stage and then the output register. The buffer RAM is read at accept and
//  written on a misprediction as the beat leaves the lookup stage; a write to the
//  slot read in that same cycle is forwarded. After reset a clear sweep zeroes all
//  1024 entries, one per cycle; s_tready stays low until the sweep ends.
//  An m stall holds the output register and then the lookup stage behind it.
`include "btb_history_xor_predictor_defines.svh"

module btb_history_xor_predictor
    import bhxp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // pc, instruction, actual_next_pc
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [PC_W-1:0]       o_m_tdata,   // predicted_next_pc
    output logic [OUT_USER_W-1:0] o_m_tuser    // buffer_hit, is_control_transfer, mispredicted
);

    logic [PC_W-1:0] in_pc;
    logic [PC_W-1:0] in_inst;
    logic [PC_W-1:0] in_actual;
    logic            accept;
    t_lookup         lookup;

    // Clear sweep state
    logic  r_clr_busy;
    t_slot r_clr_addr;

    // Lookup stage
    logic            r_s1_valid;
    t_slot           r_s1_slot;
    t_tag            r_s1_tag;
    logic            r_s1_ctl;
    logic [PC_W-1:0] r_s1_pc;
    logic [PC_W-1:0] r_s1_actual;
    logic            r_fwd_hit;
    t_entry          r_fwd_entry;

    // Output register
    logic                  r_out_valid;
    logic [PC_W-1:0]       r_out_pred;
    logic [OUT_USER_W-1:0] r_out_user;

    // RAM ports
    logic   wr_en;
    t_slot  wr_addr;
    t_entry wr_entry;
    t_entry rd_entry;
    logic [ENTRY_W-1:0] rd_data;

    // Lookup results
    t_entry          cur_entry;
    logic            s1_hit;
    logic [PC_W-1:0] s1_pred;
    logic            s1_miss;
    logic            s1_adv;

    assign in_pc     = i_s_tdata[PC_W-1:0];
    assign in_inst   = i_s_tdata[2*PC_W-1:PC_W];
    assign in_actual = i_s_tdata[3*PC_W-1:2*PC_W];

    // Handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign accept     = i_s_tvalid && o_s_tready;

    bhxp_index u_index (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pc     (in_pc),
        .i_opcode (in_inst[6:2]),
        .o_lookup (lookup)
    );

    // Compare and predict
    assign rd_entry  = t_entry'(rd_data);
    assign cur_entry = r_fwd_hit ? r_fwd_entry : rd_entry;
    assign s1_hit    = (cur_entry.tag == r_s1_tag);
    assign s1_pred   = s1_hit ? cur_entry.target : (r_s1_pc + PC_W'(4));
    assign s1_miss   = r_s1_ctl && (s1_pred != r_s1_actual);

    // Write port: clear sweep or misprediction repair
    always_comb begin
        if (r_clr_busy) begin
            wr_en    = 1'b1;
            wr_addr  = r_clr_addr;
            wr_entry = '0;
        end else begin
            wr_en           = s1_adv && s1_miss;
            wr_addr         = r_s1_slot;
            wr_entry.tag    = r_s1_tag;
            wr_entry.target = r_s1_actual;
        end
    end

    bhxp_ram #(
        .ADDR_W (INDEX_BITS),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (accept),
        .i_rd_addr (lookup.slot),
        .o_rd_data (rd_data)
    );

    // Clear sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + t_slot'(1);
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Lookup stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= wr_en && (wr_addr == lookup.slot);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Lookup stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_slot   <= lookup.slot;
            r_s1_tag    <= lookup.tag;
            r_s1_ctl    <= lookup.ctl;
            r_s1_pc     <= in_pc;
            r_s1_actual <= in_actual;
            r_fwd_entry <= wr_entry;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pred <= s1_pred;
            r_out_user <= {s1_miss, r_s1_ctl, s1_hit};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pred;
    assign o_m_tuser  = r_out_user;

    // Checks
    `BHXP_ASSERT_NOW(a_no_accept_clear, r_clr_busy, !o_s_tready,
        "beat accepted during clear sweep")
    `BHXP_ASSERT_NOW(a_miss_needs_ctl, o_m_tvalid && o_m_tuser[2], o_m_tuser[1],
        "misprediction flagged on a non-control-transfer")
    `BHXP_ASSERT_NOW(a_stall_blocks, r_s1_valid && r_out_valid && !i_m_tready, !accept,
        "beat accepted while lookup stage is stalled")
    `BHXP_ASSERT_NEXT(a_fwd_capture, accept && !r_clr_busy && wr_en && (wr_addr == lookup.slot),
        r_fwd_hit, "same-slot write not forwarded")
    `BHXP_ASSERT_NOW(a_clear_span, $fell(r_clr_busy), $past(r_clr_addr) == '1,
        "clear sweep ended early")

endmodule

[tb/sv/tb_top.sv]
// Testbench for btb_history_xor_predictor: directed table then random retire stream.
// Depends on bhxp_pkg and the predictor RTL; results checked against a local BTB model.
`timescale 1ns / 1ps

module tb_top
    import bhxp_pkg::*;
();

    localparam int CLK_HALF   = 2;
    localparam int RAND_ITEMS = 800;
    localparam int TAIL_WAIT  = 20;
    localparam int CYCLE_CAP  = 200000;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 400;
    localparam int POOL_SZ    = 8;

    // Canonical instruction words for each control opcode, plus a plain ALU op
    localparam logic [31:0] INS_NOP    = 32'h0000_0013;
    localparam logic [31:0] INS_JAL    = {25'h0, OPC_JAL, 2'b11};
    localparam logic [31:0] INS_JALR   = {25'h0, OPC_JALR, 2'b11};
    localparam logic [31:0] INS_BRANCH = {25'h0, OPC_BRANCH, 2'b11};

    typedef struct packed {
        logic [31:0] pred;
        logic        hit;
        logic        ctl;
        logic        miss;
    } t_lookup_result;

    typedef struct {
        logic [31:0]    pc;
        logic [31:0]    instr;
        logic [31:0]    actual;
        bit             typed;
        t_lookup_result want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;  // pc, instruction, actual_next_pc
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [PC_W-1:0]       o_m_tdata;       // predicted_next_pc
    logic [OUT_USER_W-1:0] o_m_tuser;       // buffer_hit, is_control_transfer, mispredicted

    // Local copy of the buffer and the global history
    t_tag        bt_tag [2**INDEX_BITS];
    logic [31:0] bt_target [2**INDEX_BITS];
    t_slot       hist_reg;
    t_slot       last_wr_slot;
    t_tag        last_wr_tag;

    t_lookup_result pending_results[$];
    t_row           directed_rows[$];
    int             err_count = 0;
    int             cycles = 0;
    int             rx_beats = 0;
    int             rx_wait = 0;
    int             hold_left = 0;
    bit             rx_burst = 1'b0;

    btb_history_xor_predictor i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Lookup, then update on control transfers; mirrors one retired instruction
    function automatic t_lookup_result predict_retire(input logic [31:0] pc,
                                                      input logic [31:0] instr,
                                                      input logic [31:0] actual);
        t_slot          slot;
        t_tag           tag;
        logic [4:0]     opc;
        t_lookup_result r;
        opc    = instr[6:2];
        slot   = pc[INDEX_BITS+1:2] ^ hist_reg;
        tag    = pc[TAG_LSB+TAG_BITS-1:TAG_LSB];
        r.hit  = (bt_tag[slot] == tag);
        r.pred = r.hit ? bt_target[slot] : pc + 32'd4;
        r.ctl  = (opc == OPC_JAL) || (opc == OPC_JALR) || (opc == OPC_BRANCH);
        r.miss = r.ctl && (r.pred != actual);
        if (r.ctl) begin
            if (r.miss) begin
                bt_tag[slot]    = tag;
                bt_target[slot] = actual;
                last_wr_slot    = slot;
                last_wr_tag     = tag;
            end
            hist_reg = (hist_reg << 2) ^ t_slot'(pc[3:2] ^ pc[5:4]);
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_ctl_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 2))
            0:       w[6:2] = OPC_JAL;
            1:       w[6:2] = OPC_JALR;
            default: w[6:2] = OPC_BRANCH;
        endcase
        return w;
    endfunction

    task automatic add_row(input logic [31:0] pc, input logic [31:0] instr,
                           input logic [31:0] actual, input bit typed,
                           input logic [31:0] epred, input logic ehit,
                           input logic ectl, input logic emiss);
        t_row row;
        row.pc     = pc;
        row.instr  = instr;
        row.actual = actual;
        row.typed  = typed;
        row.want   = '{pred: epred, hit: ehit, ctl: ectl, miss: emiss};
        directed_rows.push_back(row);
    endtask

    // Offer one beat after the requested idle gap; log the expectation at acceptance
    task automatic send_retire(input logic [31:0] pc, input logic [31:0] instr,
                               input logic [31:0] actual, input int gap,
                               input bit typed, input t_lookup_result want);
        t_lookup_result r;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {actual, instr, pc};
        do @(posedge i_clk); while (!o_s_tready);
        r = predict_retire(pc, instr, actual);
        pending_results.push_back(typed ? want : r);
    endtask

    // Stimulus: directed table, then a random retire stream
    initial begin
        logic [31:0]    pool_pc [POOL_SZ];
        logic [31:0]    pool_ins [POOL_SZ];
        logic [31:0]    pool_tgt [POOL_SZ];
        logic [31:0]    pc;
        logic [31:0]    ins;
        logic [31:0]    act;
        int             walk;
        int             mode;
        int             gap;
        bit             tx_burst;
        t_lookup_result none;

        none = '0;
        for (int i = 0; i < 2**INDEX_BITS; i++) begin
            bt_tag[i]    = '0;
            bt_target[i] = '0;
        end
        hist_reg     = '0;
        last_wr_slot = '0;
        last_wr_tag  = '0;

        // After reset: tag zero hits target zero; other opcodes never flag a miss
        add_row(32'h0000_0000, INS_NOP,      32'h0000_0004, 1, 32'h0000_0000, 1, 0, 0);
        add_row(32'h0000_F000, INS_NOP,      32'h0000_F004, 1, 32'h0000_F004, 0, 0, 0);
        add_row(32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'h0000_0000, 1, 32'h0000_0000, 0, 0, 0);
        // Correctly predicted jump keeps entry, history still moves
        add_row(32'h0000_0000, INS_JAL,      32'h0000_0000, 1, 32'h0000_0000, 1, 1, 0);
        add_row(32'h0000_0010, INS_JAL,      32'h8000_0000, 1, 32'h0000_0000, 1, 1, 1);
        add_row(32'h0000_0010, INS_JAL,      32'h8000_0000, 0, 0, 0, 0, 0);
        add_row(32'hFFFF_FFFC, INS_BRANCH,   32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        add_row(32'h1234_5678, INS_JALR,     32'h0000_0000, 0, 0, 0, 0, 0);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFE7, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        add_row(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        add_row(32'h0000_0020, INS_NOP,      32'h0000_0999, 0, 0, 0, 0, 0);
        // Small two-branch loop so entries get learned and reused
        for (int k = 0; k < 5; k++) begin
            add_row(32'h0000_1000, INS_BRANCH, 32'h0000_1040, 0, 0, 0, 0, 0);
            add_row(32'h0000_1044, INS_JAL,    32'h0000_1000, 0, 0, 0, 0, 0);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows back to back to exercise write-to-read forwarding
        foreach (directed_rows[i])
            send_retire(directed_rows[i].pc, directed_rows[i].instr,
                        directed_rows[i].actual, 0, directed_rows[i].typed,
                        directed_rows[i].want);

        walk     = 0;
        tx_burst = 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            // Refresh the little program every hundred items
            if (n % 100 == 0) begin
                for (int p = 0; p < POOL_SZ; p++) begin
                    pool_pc[p]  = $urandom();
                    pool_ins[p] = ($urandom_range(0, 3) == 0) ? $urandom() : rand_ctl_word();
                    pool_tgt[p] = $urandom();
                end
            end
            if (n % 64 == 0)
                tx_burst = ($urandom_range(0, 2) == 0);

            mode = $urandom_range(0, 99);
            if (mode < 60) begin
                // Loop over the program; mostly stable outcomes
                pc   = pool_pc[walk];
                ins  = pool_ins[walk];
                act  = ($urandom_range(0, 4) == 0) ? pc + 32'd4 : pool_tgt[walk];
                walk = (walk + 1) % POOL_SZ;
            end else if (mode < 75) begin
                // Aim at the slot last rewritten, often with its tag
                pc = $urandom();
                pc[INDEX_BITS+1:2] = last_wr_slot ^ hist_reg;
                if ($urandom_range(0, 1))
                    pc[TAG_LSB+TAG_BITS-1:TAG_LSB] = last_wr_tag;
                ins = ($urandom_range(0, 1)) ? rand_ctl_word() : $urandom();
                act = $urandom();
            end else begin
                pc  = $urandom();
                ins = $urandom();
                act = $urandom();
            end
            gap = tx_burst ? 0 : $urandom_range(0, 9);
            send_retire(pc, ins, act, gap, 0, none);
        end
        i_s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result side: per-beat stall draw, one long hold-off, field checks
    initial begin
        t_lookup_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing pending: pred %h user %b",
                           o_m_tdata, o_m_tuser);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_tdata !== want.pred) begin
                        $error("predicted_next_pc: expected %h actual %h", want.pred, o_m_tdata);
                        err_count++;
                    end
                    if (o_m_tuser[0] !== want.hit) begin
                        $error("buffer_hit: expected %b actual %b", want.hit, o_m_tuser[0]);
                        err_count++;
                    end
                    if (o_m_tuser[1] !== want.ctl) begin
                        $error("is_control_transfer: expected %b actual %b",
                               want.ctl, o_m_tuser[1]);
                        err_count++;
                    end
                    if (o_m_tuser[2] !== want.miss) begin
                        $error("mispredicted: expected %b actual %b", want.miss, o_m_tuser[2]);
                        err_count++;
                    end
                end
                rx_beats++;
                if (rx_beats == HOLD_AT)
                    hold_left = HOLD_LEN;
                if ($urandom_range(0, 99) < 5)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            if (!i_rst_n) begin
                i_m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= (rx_wait == 0);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycles < CYCLE_CAP) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
